>>> rtl/crce_pkg.sv
// Shared constants, types and helpers of the Catmull-Rom curve editor.
`default_nettype none

package crce_pkg;

    // Store geometry
    localparam int POINTS  = 11;
    localparam int STEPS   = 10;
    localparam int ENTRIES = STEPS * POINTS;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int PT_W    = $clog2(POINTS);

    // Fixed field widths
    localparam int SEL_W   = 4;
    localparam int COORD_W = 16;
    localparam int OUT_W   = 24;

    // Arithmetic widths: weights at scale 2^25, products, four-term sum
    localparam int WGT_W  = 28;
    localparam int PROD_W = WGT_W + COORD_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC_SHIFT = 17;

    // Key codes
    localparam logic [7:0] KEY_STEP_NEXT  = 8'h73; // s
    localparam logic [7:0] KEY_STEP_PREV  = 8'h53; // S
    localparam logic [7:0] KEY_POINT_NEXT = 8'h70; // p
    localparam logic [7:0] KEY_POINT_PREV = 8'h50; // P
    localparam logic [7:0] KEY_X_DOWN     = 8'h68; // h
    localparam logic [7:0] KEY_Y_UP       = 8'h6A; // j
    localparam logic [7:0] KEY_Y_DOWN     = 8'h6B; // k
    localparam logic [7:0] KEY_X_UP       = 8'h6C; // l

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_WB,
        ST_SMP
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } coord_pair_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PT_W-1:0]   pt;
    } store_rd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        coord_pair_t       data;
    } store_wr_t;

    // Default x of a point that was never written: -50 + 10*pt tenths
    function automatic logic signed [COORD_W-1:0] rst_x(input logic [PT_W-1:0] pt);
        int v;
        v = -50 + 10 * int'(pt);
        return COORD_W'(v);
    endfunction

    // Store address of a point within a step
    function automatic logic [ADDR_W-1:0] crce_addr(input logic [SEL_W-1:0] step,
                                                    input logic [PT_W-1:0]  pt);
        int a;
        a = int'(step) * POINTS + int'(pt);
        return ADDR_W'(a);
    endfunction

endpackage

`default_nettype wire

>>> rtl/crce_store.sv
// Control point store: 1R1W RAM with per-entry valid bits for reset defaults.
`default_nettype none

module crce_store
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire crce_pkg::store_rd_t  rd,
    input  wire crce_pkg::store_wr_t  wr,
    output crce_pkg::coord_pair_t     rd_data
);
    import crce_pkg::*;

    coord_pair_t       mem [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    coord_pair_t       q_reg;
    logic              q_vld_reg;
    logic [PT_W-1:0]   q_pt_reg;

    // Write the entry and read one address per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        q_reg    <= mem[rd.addr];
        q_pt_reg <= rd.pt;
    end

    // Mark written entries; reset returns every entry to its default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            q_vld_reg <= vld_reg[rd.addr];
        end
    end

    // Substitute the default point for an entry never written
    always_comb
    begin
        if (q_vld_reg)
        begin
            rd_data = q_reg;
        end
        else
        begin
            rd_data.x = rst_x(q_pt_reg);
            rd_data.y = '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/catmull_rom_curve_editor.sv
// Top level of the Catmull-Rom curve editor: selection, nudging and curve sampling.
`default_nettype none

// The block holds STEPS rows of POINTS control points in a store with one read port
// and one write port, and answers every accepted word with exactly one result word.
// A key event passes from acceptance through a store read to the write back; a
// sample squares the fraction at acceptance, then cubes it and turns it into the
// four weights, and the four control points are then read one per cycle through
// the store's single read port into a multiply and accumulate pair, followed by
// the floor and saturation step. A new word is taken in the cycle after a result
// is loaded, while that result may still wait on m_tready. After reset every
// point reads as x = -50 + 10*i tenths, y = 0, with no clearing pass.
module catmull_rom_curve_editor
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // key_code[7:0], segment[11:8], fraction[19:12]
    input  wire logic [0:0]  s_tuser,  // cmd[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata   // sample_x[23:0], sample_y[47:24],
                                       // cur_step[51:48], cur_point[55:52]
);
    import crce_pkg::*;

    state_t            state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [SEL_W-1:0]  sel_step_reg, sel_step_next;
    logic [SEL_W-1:0]  sel_point_reg, sel_point_next;
    logic              out_vld_reg, out_vld_next;

    logic [7:0]        key_reg;
    logic [7:0]        t_reg;
    logic [15:0]       t2_reg;
    logic [23:0]       t3_reg;
    logic [PT_W-1:0]   pb_reg;
    logic signed [WGT_W-1:0]  w_reg [4];
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    logic [OUT_W-1:0]  out_x_reg, out_y_reg;
    logic [SEL_W-1:0]  out_step_reg, out_point_reg;

    logic              in_acc;
    logic              slot_free;
    logic              cmd_in;
    logic [7:0]        key_in;
    logic [3:0]        seg_in;
    logic [7:0]        frac_in;
    logic [PT_W-1:0]   seg_clamped;
    logic              nudge_key;

    store_rd_t         st_rd;
    store_wr_t         st_wr;
    coord_pair_t       st_q;
    coord_pair_t       nudged;

    crce_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (st_rd),
        .wr      (st_wr),
        .rd_data (st_q)
    );

    // Unpack the input word
    assign cmd_in  = s_tuser[0];
    assign key_in  = s_tdata[7:0];
    assign seg_in  = s_tdata[11:8];
    assign frac_in = s_tdata[19:12];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign slot_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_point_reg, out_step_reg, out_y_reg, out_x_reg};

    // Clamp the segment index to 1..POINTS-3
    always_comb
    begin
        if (seg_in == 4'd0)
        begin
            seg_clamped = PT_W'(1);
        end
        else if (int'(seg_in) > POINTS - 3)
        begin
            seg_clamped = PT_W'(POINTS - 3);
        end
        else
        begin
            seg_clamped = PT_W'(seg_in);
        end
    end

    // Saturating +-1 nudge of a coordinate
    function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] v,
                                                        input logic up);
        logic signed [COORD_W:0] r;
        r = {v[COORD_W-1], v} + (up ? (COORD_W+1)'(1) : {(COORD_W+1){1'b1}});
        if (r[COORD_W] != r[COORD_W-1])
        begin
            return r[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r[COORD_W-1:0];
    endfunction

    // Floor to 8 fraction bits and saturate to the output range
    function automatic logic [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-FRAC_SHIFT-OUT_W:0] top;
        top = a[ACC_W-1:FRAC_SHIFT+OUT_W-1];
        if ((top != '0) && (top != '1))
        begin
            return a[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return a[FRAC_SHIFT+OUT_W-1:FRAC_SHIFT];
    endfunction

    // Decode nudge keys and form the nudged point
    always_comb
    begin
        nudge_key = 1'b0;
        nudged    = st_q;
        unique case (key_reg)
            KEY_X_DOWN:
            begin
                nudge_key = 1'b1;
                nudged.x  = nudge(st_q.x, 1'b0);
            end
            KEY_X_UP:
            begin
                nudge_key = 1'b1;
                nudged.x  = nudge(st_q.x, 1'b1);
            end
            KEY_Y_UP:
            begin
                nudge_key = 1'b1;
                nudged.y  = nudge(st_q.y, 1'b1);
            end
            KEY_Y_DOWN:
            begin
                nudge_key = 1'b1;
                nudged.y  = nudge(st_q.y, 1'b0);
            end
            default:
            begin
                nudge_key = 1'b0;
            end
        endcase
    end

    // Store read address: the selected point, or the next of the four sample points
    always_comb
    begin
        logic [PT_W-1:0] pt;
        pt = sel_point_reg[PT_W-1:0];
        if (state_reg == ST_SMP)
        begin
            pt = pb_reg + PT_W'(cnt_reg - 3'd1);
        end
        st_rd.pt   = pt;
        st_rd.addr = crce_addr(sel_step_reg, pt);
    end

    // Write back a nudged point as the key result leaves
    always_comb
    begin
        st_wr.en   = (state_reg == ST_KEY_WB) && slot_free && nudge_key;
        st_wr.addr = crce_addr(sel_step_reg, sel_point_reg[PT_W-1:0]);
        st_wr.data = nudged;
    end

    // Sequencer: next state, selection and output valid
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_step_next  = sel_step_reg;
        sel_point_next = sel_point_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                begin
                    if (cmd_in)
                    begin
                        state_next = ST_SMP;
                    end
                    else
                    begin
                        state_next = ST_KEY_RD;
                        case (key_in)
                            KEY_STEP_NEXT:
                                sel_step_next = (int'(sel_step_reg) >= STEPS - 1) ?
                                                '0 : sel_step_reg + 1'b1;
                            KEY_STEP_PREV:
                                sel_step_next = (sel_step_reg == '0) ?
                                                SEL_W'(STEPS - 1) : sel_step_reg - 1'b1;
                            KEY_POINT_NEXT:
                                sel_point_next = (int'(sel_point_reg) >= POINTS - 1) ?
                                                 '0 : sel_point_reg + 1'b1;
                            KEY_POINT_PREV:
                                sel_point_next = (sel_point_reg == '0) ?
                                                 SEL_W'(POINTS - 1) : sel_point_reg - 1'b1;
                            default:
                            begin
                                sel_step_next = sel_step_reg;
                            end
                        endcase
                    end
                end
            end
            ST_KEY_RD:
            begin
                state_next = ST_KEY_WB;
            end
            ST_KEY_WB:
            begin
                if (slot_free)
                begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SMP:
            begin
                if (cnt_reg == 3'd7)
                begin
                    if (slot_free)
                    begin
                        out_vld_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_step_reg  <= '0;
            sel_point_reg <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_step_reg  <= sel_step_next;
            sel_point_reg <= sel_point_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Latch the accepted word and square the fraction
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            key_reg <= key_in;
            t_reg   <= frac_in;
            t2_reg  <= {8'b0, frac_in} * {8'b0, frac_in};
            pb_reg  <= seg_clamped - PT_W'(1);
        end
    end

    // Cube, weights, multiply and accumulate of the sample
    always_ff @(posedge clk)
    begin
        logic signed [WGT_W-1:0]  t_e, t2_e, t3_e;
        logic [1:0]               mk;
        t_e  = WGT_W'(t_reg);
        t2_e = WGT_W'(t2_reg);
        t3_e = WGT_W'(t3_reg);
        mk   = 2'(cnt_reg - 3'd2);

        if (state_reg == ST_SMP && cnt_reg == 3'd0)
        begin
            t3_reg <= {8'b0, t2_reg} * {16'b0, t_reg};
        end
        if (state_reg == ST_SMP && cnt_reg == 3'd1)
        begin
            w_reg[0] <= -t3_e + (t2_e <<< 9) - (t_e <<< 16);
            w_reg[1] <= (t3_e <<< 1) + t3_e - (t2_e <<< 10) - (t2_e <<< 8)
                        + WGT_W'(33554432);
            w_reg[2] <= -((t3_e <<< 1) + t3_e) + (t2_e <<< 10) + (t_e <<< 16);
            w_reg[3] <= t3_e - (t2_e <<< 8);
        end

        // Multiply the point just read by its weight
        prod_x_reg <= st_q.x * w_reg[mk];
        prod_y_reg <= st_q.y * w_reg[mk];

        // Clear at acceptance, then add the four products
        if (in_acc)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (state_reg == ST_SMP && cnt_reg >= 3'd3 && cnt_reg <= 3'd6)
        begin
            acc_x_reg <= acc_x_reg + ACC_W'(prod_x_reg);
            acc_y_reg <= acc_y_reg + ACC_W'(prod_y_reg);
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_KEY_WB && slot_free)
        begin
            out_x_reg     <= {nudged.x, 8'h00};
            out_y_reg     <= {nudged.y, 8'h00};
            out_step_reg  <= sel_step_reg;
            out_point_reg <= sel_point_reg;
        end
        else if (state_reg == ST_SMP && cnt_reg == 3'd7 && slot_free)
        begin
            out_x_reg     <= scale_sat(acc_x_reg);
            out_y_reg     <= scale_sat(acc_y_reg);
            out_step_reg  <= sel_step_reg;
            out_point_reg <= sel_point_reg;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench of the Catmull-Rom curve editor: selection, nudging and sampling.
`timescale 1ns / 100ps

module testbench;

    import crce_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 100;

    // Command selector and keys that the editor does not know
    localparam logic CMD_KEY    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;
    localparam logic [7:0] KEY_UNKNOWN = 8'h61; // a
    localparam logic [7:0] KEY_NUL     = 8'h00;
    localparam logic [7:0] KEY_ALL_ONE = 8'hFF;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [SEL_W-1:0]        step;
        logic [SEL_W-1:0]        point;
    } editor_out_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  key;
        logic [3:0]  seg;
        logic [7:0]  frac;
        bit          chk;
        editor_out_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;  // key_code[7:0], segment[11:8], fraction[19:12]
    logic [0:0]  s_tuser = '0;  // cmd[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;       // sample_x[23:0], sample_y[47:24],
                                // cur_step[51:48], cur_point[55:52]

    // Predictor state: control points and selection
    int pt_x [STEPS][POINTS];
    int pt_y [STEPS][POINTS];
    int sel_step;
    int sel_point;

    editor_out_t editor_out_q[$];
    stim_row_t   stim_tab[$];

    int snd_pct = 0;
    int rcv_pct = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    catmull_rom_curve_editor DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Saturate a coordinate to 16 bits signed
    function automatic int clip_coord(input int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    // Floor to 8 fraction bits, then saturate to the 24-bit result range
    function automatic logic signed [OUT_W-1:0] floor_sat(input longint v);
        longint q;
        q = v >>> 17;
        if (q > 64'sd8388607)
        begin
            q = 64'sd8388607;
        end
        if (q < -64'sd8388608)
        begin
            q = -64'sd8388608;
        end
        return OUT_W'(q);
    endfunction

    // Apply one input word to the predictor state and return the result word
    function automatic editor_out_t editor_apply(input logic cmd, input logic [7:0] key,
                                                 input logic [3:0] seg, input logic [7:0] frac);
        editor_out_t r;
        int i;
        longint t, t2, t3, w1, w2, w3, w4, ax, ay;
        if (cmd == CMD_KEY)
        begin
            case (key)
                KEY_STEP_NEXT:  sel_step  = (sel_step + 1 >= STEPS) ? 0 : sel_step + 1;
                KEY_STEP_PREV:  sel_step  = (sel_step == 0) ? STEPS - 1 : sel_step - 1;
                KEY_POINT_NEXT: sel_point = (sel_point + 1 >= POINTS) ? 0 : sel_point + 1;
                KEY_POINT_PREV: sel_point = (sel_point == 0) ? POINTS - 1 : sel_point - 1;
                KEY_Y_UP:
                    pt_y[sel_step][sel_point] = clip_coord(pt_y[sel_step][sel_point] + 1);
                KEY_Y_DOWN:
                    pt_y[sel_step][sel_point] = clip_coord(pt_y[sel_step][sel_point] - 1);
                KEY_X_DOWN:
                    pt_x[sel_step][sel_point] = clip_coord(pt_x[sel_step][sel_point] - 1);
                KEY_X_UP:
                    pt_x[sel_step][sel_point] = clip_coord(pt_x[sel_step][sel_point] + 1);
                default: ;
            endcase
            r.x = OUT_W'(pt_x[sel_step][sel_point] * 256);
            r.y = OUT_W'(pt_y[sel_step][sel_point] * 256);
        end
        else
        begin
            i = int'(seg);
            if (i < 1)
            begin
                i = 1;
            end
            if (i > POINTS - 3)
            begin
                i = POINTS - 3;
            end
            t  = longint'(frac);
            t2 = t * t;
            t3 = t2 * t;
            // Weights at scale 2^25
            w1 = -t3 + 512 * t2 - 65536 * t;
            w2 = 3 * t3 - 1280 * t2 + 33554432;
            w3 = -3 * t3 + 1024 * t2 + 65536 * t;
            w4 = t3 - 256 * t2;
            ax = w1 * pt_x[sel_step][i-1] + w2 * pt_x[sel_step][i]
               + w3 * pt_x[sel_step][i+1] + w4 * pt_x[sel_step][i+2];
            ay = w1 * pt_y[sel_step][i-1] + w2 * pt_y[sel_step][i]
               + w3 * pt_y[sel_step][i+1] + w4 * pt_y[sel_step][i+2];
            r.x = floor_sat(ax);
            r.y = floor_sat(ay);
        end
        r.step  = SEL_W'(sel_step);
        r.point = SEL_W'(sel_point);
        return r;
    endfunction

    // Add one row to the directed stimulus
    task automatic tab(input logic c, input logic [7:0] k, input logic [3:0] sg,
                       input logic [7:0] f, input bit chk,
                       input int ex, input int ey, input int es, input int ep);
        stim_row_t row;
        row.cmd = c;
        row.key = k;
        row.seg = sg;
        row.frac = f;
        row.chk = chk;
        row.want.x = OUT_W'(ex);
        row.want.y = OUT_W'(ey);
        row.want.step = SEL_W'(es);
        row.want.point = SEL_W'(ep);
        stim_tab.push_back(row);
    endtask

    // Offer one word, hold it until taken, then queue its expected result
    task automatic send_word(input stim_row_t row);
        editor_out_t pred;
        while ($urandom_range(99) < snd_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tdata  <= {4'b0000, row.frac, row.seg, row.key};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pred = editor_apply(row.cmd, row.key, row.seg, row.frac);
        editor_out_q.push_back(row.chk ? row.want : pred);
    endtask

    // Mostly known keys and samples with random content, some unknown keys
    task automatic random_burst(input int n);
        int done;
        int r;
        bit known;
        stim_row_t row;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(99);
            row.key  = 8'($urandom_range(255));
            row.seg  = 4'($urandom_range(15));
            row.frac = 8'($urandom_range(255));
            row.chk  = 1'b0;
            row.want = '0;
            if (r < 45)
            begin
                row.cmd = CMD_SAMPLE;
                if ($urandom_range(9) == 0)
                begin
                    row.frac = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
                end
                done++;
            end
            else if (r < 90)
            begin
                row.cmd = CMD_KEY;
                case ($urandom_range(7))
                    0: row.key = KEY_STEP_NEXT;
                    1: row.key = KEY_STEP_PREV;
                    2: row.key = KEY_POINT_NEXT;
                    3: row.key = KEY_POINT_PREV;
                    4: row.key = KEY_X_DOWN;
                    5: row.key = KEY_Y_UP;
                    6: row.key = KEY_Y_DOWN;
                    default: row.key = KEY_X_UP;
                endcase
                done++;
            end
            else
            begin
                row.cmd = CMD_KEY;
                case (row.key)
                    KEY_STEP_NEXT, KEY_STEP_PREV, KEY_POINT_NEXT, KEY_POINT_PREV,
                    KEY_X_DOWN, KEY_X_UP, KEY_Y_UP, KEY_Y_DOWN: known = 1'b1;
                    default: known = 1'b0;
                endcase
                if (known)
                begin
                    done++;
                end
            end
            send_word(row);
        end
    endtask

    // Drive the receiver stall and check every result word
    always @(posedge clk)
    begin
        editor_out_t want;
        editor_out_t got;
        m_tready <= ($urandom_range(99) >= rcv_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[23:0], m_tdata[47:24], m_tdata[51:48], m_tdata[55:52]};
            if (editor_out_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                begin
                    $error("result word with nothing expected: %h", m_tdata);
                end
            end
            else
            begin
                want = editor_out_q.pop_front();
                if (got.x !== want.x)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $error("sample_x: expected %0d, got %0d", want.x, got.x);
                    end
                end
                if (got.y !== want.y)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $error("sample_y: expected %0d, got %0d", want.y, got.y);
                    end
                end
                if (got.step !== want.step)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $error("cur_step: expected %0d, got %0d", want.step, got.step);
                    end
                end
                if (got.point !== want.point)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $error("cur_point: expected %0d, got %0d", want.point, got.point);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        // Reset image of the store
        for (int s = 0; s < STEPS; s++)
        begin
            for (int p = 0; p < POINTS; p++)
            begin
                pt_x[s][p] = -50 + 10 * p;
                pt_y[s][p] = 0;
            end
        end
        sel_step = 0;
        sel_point = 0;

        // Directed rows: unknown keys, wraps, clamped segments, nudges
        tab(CMD_KEY,    KEY_UNKNOWN,    4'd0,  8'd0,   1, -12800, 0,    0, 0);
        tab(CMD_KEY,    KEY_NUL,        4'd15, 8'hFF,  1, -12800, 0,    0, 0);
        tab(CMD_KEY,    KEY_ALL_ONE,    4'd0,  8'd0,   1, -12800, 0,    0, 0);
        tab(CMD_KEY,    KEY_STEP_PREV,  4'd0,  8'd0,   1, -12800, 0,    9, 0);
        tab(CMD_KEY,    KEY_STEP_NEXT,  4'd0,  8'd0,   1, -12800, 0,    0, 0);
        tab(CMD_KEY,    KEY_POINT_PREV, 4'd0,  8'd0,   1, 12800,  0,    0, 10);
        tab(CMD_KEY,    KEY_POINT_NEXT, 4'd0,  8'd0,   1, -12800, 0,    0, 0);
        tab(CMD_SAMPLE, KEY_NUL,        4'd0,  8'd0,   1, -10240, 0,    0, 0);
        tab(CMD_SAMPLE, KEY_NUL,        4'd15, 8'd0,   1, 7680,   0,    0, 0);
        tab(CMD_SAMPLE, KEY_ALL_ONE,    4'd1,  8'hFF,  1, -7690,  0,    0, 0);
        tab(CMD_SAMPLE, KEY_NUL,        4'd15, 8'hFF,  1, 10230,  0,    0, 0);
        tab(CMD_SAMPLE, KEY_NUL,        4'd4,  8'd128, 1, -1280,  0,    0, 0);
        tab(CMD_KEY,    KEY_X_UP,       4'd0,  8'd0,   1, -12544, 0,    0, 0);
        tab(CMD_KEY,    KEY_Y_UP,       4'd0,  8'd0,   1, -12544, 256,  0, 0);
        tab(CMD_KEY,    KEY_Y_DOWN,     4'd0,  8'd0,   1, -12544, 0,    0, 0);
        tab(CMD_KEY,    KEY_X_DOWN,     4'd0,  8'd0,   1, -12800, 0,    0, 0);
        tab(CMD_KEY,    KEY_Y_UP,       4'd0,  8'd0,   1, -12800, 256,  0, 0);
        tab(CMD_SAMPLE, KEY_NUL,        4'd1,  8'd64,  0, 0,      0,    0, 0);
        tab(CMD_KEY,    KEY_POINT_NEXT, 4'd0,  8'd0,   1, -10240, 0,    0, 1);
        tab(CMD_KEY,    KEY_Y_DOWN,     4'd0,  8'd0,   1, -10240, -256, 0, 1);
        tab(CMD_SAMPLE, KEY_NUL,        4'd1,  8'd200, 0, 0,      0,    0, 0);
        tab(CMD_SAMPLE, KEY_ALL_ONE,    4'd15, 8'hAA,  0, 0,      0,    0, 0);
        tab(CMD_SAMPLE, KEY_STEP_NEXT,  4'd2,  8'h55,  0, 0,      0,    0, 0);
        tab(CMD_KEY,    KEY_STEP_PREV,  4'd0,  8'd0,   1, -10240, 0,    9, 1);
        tab(CMD_KEY,    KEY_STEP_NEXT,  4'd0,  8'd0,   1, -10240, -256, 0, 1);

        // Hold reset, then release it at a clock edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles little, receiver stalls a lot
        snd_pct = 11;
        rcv_pct = 87;
        foreach (stim_tab[n])
        begin
            send_word(stim_tab[n]);
        end
        random_burst(120);

        // Sender idles a lot, receiver stalls little
        snd_pct = 87;
        rcv_pct = 11;
        random_burst(120);

        // Full rate on both sides
        snd_pct = 0;
        rcv_pct = 0;
        random_burst(110);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (editor_out_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && editor_out_q.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> catmull_rom_curve_editor.f
rtl/crce_pkg.sv
rtl/crce_store.sv
rtl/catmull_rom_curve_editor.sv
tb/sv/testbench.sv
